// ===== src/qfmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote feed message parser package
// Shared payload types, character codes and field helpers.
// ----------------------------------------------------------------------------
package qfmp_pkg;

    localparam int PriceDigitCount = 12;
    localparam int QueueDepth      = 2;
    localparam int BodyStart       = 25;

    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChDot      = 8'h2E;
    localparam logic [7:0] ChZero     = 8'h30;
    localparam logic [7:0] ChOne      = 8'h31;
    localparam logic [7:0] ChFour     = 8'h34;
    localparam logic [7:0] ChSix      = 8'h36;
    localparam logic [7:0] ChLetterA  = 8'h41;
    localparam logic [7:0] ChLetterB  = 8'h42;
    localparam logic [7:0] ChLetterD  = 8'h44;
    localparam logic [7:0] ChLetterE  = 8'h45;
    localparam logic [7:0] ChLetterF  = 8'h46;
    localparam logic [7:0] ChLetterH  = 8'h48;
    localparam logic [7:0] ChLetterO  = 8'h4F;

    localparam logic RegNbboMode   = 1'b0;
    localparam logic RegNbboSuffix = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic        side;
        logic [63:0] symbol_head;
        logic [39:0] symbol_tail;
        logic [3:0]  symbol_length;
        logic [7:0]  quote_kind;
        logic [39:0] price_digits;
        logic [3:0]  price_power;
        logic [23:0] quantity;
        logic [26:0] timestamp_ms;
        logic [29:0] sequence_number;
        logic [7:0]  participant;
        logic        last_of_run;
    } out_t;

    typedef struct packed {
        logic [39:0] digits;
        logic [3:0]  power;
        logic [23:0] qty;
    } side_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] suffix;
    } cfg_t;

    // One complete quote, handed from the parser to the result stage.
    typedef struct packed {
        logic [63:0] symbol_head;
        logic [39:0] symbol_tail;
        logic [3:0]  symbol_length;
        logic [7:0]  quote_kind;
        side_t       bid;
        side_t       ask;
        logic [26:0] timestamp_ms;
        logic [29:0] sequence_number;
        logic [7:0]  participant;
    } msg_t;

    function automatic logic [3:0] power_of(logic [7:0] c);
        logic [7:0] d;
        d = c - ChLetterA;
        if (c >= ChLetterA && c <= ChLetterH) begin
            return d[3:0] + 4'd1;
        end
        return 4'd0;
    endfunction

    function automatic logic [26:0] time_weight(logic [2:0] idx);
        case (idx)
            3'd0:    return 27'd3600000;
            3'd1:    return 27'd60000;
            3'd2:    return 27'd1000;
            3'd3:    return 27'd100;
            3'd4:    return 27'd10;
            default: return 27'd1;
        endcase
    endfunction

    // Applies one byte to a side's denominator, price or size field.
    function automatic side_t take_field(side_t f, int r, int dpos, int ppos, int plen,
                                         int spos, int slen, logic [7:0] b);
        side_t       o;
        logic [39:0] d;
        logic [23:0] q;
        logic [7:0]  v;
        o = f;
        v = b - ChZero;
        if (r == dpos) begin
            o.power = power_of(b);
        end else if (r >= ppos && r < ppos + plen) begin
            d = (r == ppos) ? 40'd0 : f.digits;
            o.digits = (d << 3) + (d << 1) + {32'd0, v};
        end else if (r >= spos && r < spos + slen) begin
            q = (r == spos) ? 24'd0 : f.qty;
            o.qty = (q << 3) + (q << 1) + {16'd0, v};
        end
        return o;
    endfunction

endpackage

// ===== src/quote_feed_message_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote feed message parser
// Byte-serial decoder of fixed-offset quote messages into bid and ask results.
// ----------------------------------------------------------------------------
// The parser takes one message byte per transfer, every clock cycle while the
// queue has room, starting with the SOH byte; first_byte forces a new message
// and end_of_message closes it. Header and body fields are accumulated as the
// bytes pass, so the last byte of a quote produces the complete record at once.
// The record goes into a two-entry queue, from which the result stage emits the
// bid and then the ask result through an output register. Input stalls only
// when that queue is full, which needs two finished quotes waiting on a stalled
// result channel. Configuration is read over the APB port at byte address 0
// (NBBO mode) and 4 (NBBO suffix) and should be written while idle.
// ----------------------------------------------------------------------------
module quote_feed_message_parser #(
    parameter int MAX_SYMBOL_CHARS = 11
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qfmp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output qfmp_pkg::out_t m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import qfmp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_push, q_pop, head_valid;
    msg_t q_data, head;

    // Registers sit at word addresses; bit 2 of the address picks one.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegNbboSuffix) ? {24'd0, cfg_reg.suffix}
                                                : {31'd0, cfg_reg.mode};

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                RegNbboMode:   cfg_next.mode   = pwdata[0];
                RegNbboSuffix: cfg_next.suffix = pwdata[7:0];
                default:       cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qfmp_front #(
        .MAX_SYMBOL_CHARS(MAX_SYMBOL_CHARS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    qfmp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    qfmp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== src/qfmp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote feed parser front end
// Takes one message byte per transfer and builds a complete quote record.
// ----------------------------------------------------------------------------
module qfmp_front #(
    parameter int MAX_SYMBOL_CHARS = 11
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qfmp_pkg::in_t  s_data,
    input  qfmp_pkg::cfg_t cfg,
    input  logic           q_full,
    output logic           q_push,
    output qfmp_pkg::msg_t q_data
);
    import qfmp_pkg::*;

    localparam int IW  = (MAX_SYMBOL_CHARS > 1) ? $clog2(MAX_SYMBOL_CHARS) : 1;
    localparam int CW  = $clog2(MAX_SYMBOL_CHARS + 1);
    localparam int LQt  = MAX_SYMBOL_CHARS + 13;
    localparam int LBd  = LQt + 3;
    localparam int LBp  = LBd + 1;
    localparam int LBs  = LBp + PriceDigitCount;
    localparam int LAd  = LBs + 7;
    localparam int LAp  = LAd + 1;
    localparam int LAs  = LAp + PriceDigitCount;
    localparam int LInd = LAs + 16;
    localparam int LApx = LInd + 2;
    localparam int SInd = 32;
    localparam int SApx = 34;

    logic [7:0]    offset_reg, offset_next;
    logic [7:0]    type_reg [3];
    logic [7:0]    type_next [3];
    logic          orig_reg, orig_next;
    logic [29:0]   seq_reg, seq_next;
    logic [7:0]    part_reg, part_next;
    logic [26:0]   time_reg, time_next;
    logic [7:0]    store_reg [MAX_SYMBOL_CHARS];
    logic [7:0]    store_next [MAX_SYMBOL_CHARS];
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    kind_reg, kind_next;
    side_t         bid_reg, bid_next, ask_reg, ask_next;
    logic [7:0]    ind_reg, ind_next;

    logic          accept;
    logic [7:0]    pos, r, b, v;
    logic [2:0]    tidx;
    logic          is_long, emit, tag;
    int            ri, symlen, ind, apx, need, a, n;
    logic [7:0]    ch [13];

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign v       = b - ChZero;
    assign pos     = s_data.first_byte ? 8'd0 : offset_reg;
    assign r       = pos - 8'(BodyStart);
    assign ri      = int'(r);
    assign tidx    = 3'(pos - 8'd19);

    always_comb begin
        offset_next = offset_reg;
        type_next   = type_reg;
        orig_next   = orig_reg;
        seq_next    = seq_reg;
        part_next   = part_reg;
        time_next   = time_reg;
        store_next  = store_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        bid_next    = bid_reg;
        ask_next    = ask_reg;
        ind_next    = ind_reg;
        is_long     = (type_reg[1] == ChLetterB);
        symlen      = is_long ? MAX_SYMBOL_CHARS : 3;
        ind         = is_long ? LInd : SInd;
        apx         = is_long ? LApx : SApx;
        a           = ri - apx;
        if (accept) begin
            if (pos == 8'd0) begin
                type_next  = '{default: 8'd0};
                orig_next  = 1'b0;
                seq_next   = '0;
                part_next  = '0;
                time_next  = '0;
                count_next = '0;
                kind_next  = '0;
                bid_next   = '0;
                ask_next   = '0;
                ind_next   = '0;
            end else if (pos <= 8'd3) begin
                type_next[2'(pos - 8'd1)] = b;
            end else if (pos == 8'd4) begin
                orig_next = (b == ChLetterO);
            end else if (pos >= 8'd9 && pos <= 8'd17) begin
                seq_next = ((pos == 8'd9) ? 30'd0 : (seq_reg << 3) + (seq_reg << 1))
                           + {22'd0, v};
            end else if (pos == 8'd18) begin
                part_next = b;
            end else if (pos >= 8'd19 && pos <= 8'd24) begin
                time_next = ((pos == 8'd19) ? 27'd0 : time_reg)
                            + 27'({19'd0, v} * time_weight(tidx));
            end else if (pos >= 8'(BodyStart) &&
                         (type_reg[1] == ChLetterD || type_reg[1] == ChLetterB)) begin
                if (ri < symlen && int'(count_reg) == ri && b != ChSpace) begin
                    store_next[r[IW-1:0]] = b;
                    count_next = count_reg + 1'b1;
                end
                if (ri == (is_long ? LQt : 3)) begin
                    kind_next = b;
                end
                if (is_long) begin
                    bid_next = take_field(bid_reg, ri, LBd, LBp, PriceDigitCount, LBs, 7, b);
                    ask_next = take_field(ask_reg, ri, LAd, LAp, PriceDigitCount, LAs, 7, b);
                end else begin
                    bid_next = take_field(bid_reg, ri, 6, 7, 8, 15, 3, b);
                    ask_next = take_field(ask_reg, ri, 19, 20, 8, 28, 3, b);
                end
                if (ri == ind) begin
                    ind_next = b;
                end
                if (ri >= apx && cfg.mode) begin
                    if (ind_next == ChFour) begin
                        bid_next = take_field(bid_next, a, 3, 4, PriceDigitCount,
                                              4 + PriceDigitCount, 7, b);
                        ask_next = take_field(ask_next, a, 19 + PriceDigitCount,
                                              20 + PriceDigitCount, PriceDigitCount,
                                              20 + 2 * PriceDigitCount, 7, b);
                    end else if (ind_next == ChSix) begin
                        bid_next = take_field(bid_next, a, 1, 2, 8, 10, 3, b);
                        ask_next = take_field(ask_next, a, 15, 16, 8, 24, 3, b);
                    end
                end
            end
            if (s_data.end_of_message) begin
                offset_next = 8'd0;
            end else begin
                offset_next = (pos == 8'd255) ? 8'd255 : pos + 8'd1;
            end
        end
    end

    // Decide whether the message that ends on this byte yields results.
    always_comb begin
        need = (type_next[1] == ChLetterB) ? LInd + 1 : SInd + 1;
        emit = orig_next && type_next[0] == ChLetterE &&
               (type_next[2] == ChLetterE || type_next[2] == ChLetterF) &&
               (type_next[1] == ChLetterD || type_next[1] == ChLetterB);
        if (cfg.mode) begin
            if (ind_next == ChFour) begin
                need = ((type_next[1] == ChLetterB) ? LApx : SApx) + 26 + 2 * PriceDigitCount;
            end else if (ind_next == ChSix) begin
                need = ((type_next[1] == ChLetterB) ? LApx : SApx) + 26;
            end else if (ind_next != ChOne) begin
                emit = 1'b0;
            end
        end
        if (int'(pos) < BodyStart + need) begin
            emit = 1'b0;
        end
    end

    assign q_push = accept && s_data.end_of_message && emit;

    // Symbol with its optional tag, truncated to thirteen characters.
    always_comb begin
        tag = !cfg.mode || (cfg.suffix != 8'd0);
        n   = int'(count_next) + (tag ? 2 : 0);
        if (n > 13) begin
            n = 13;
        end
        for (int k = 0; k < 13; k++) begin
            if (k < MAX_SYMBOL_CHARS && k < int'(count_next)) begin
                ch[k] = store_next[(k < MAX_SYMBOL_CHARS) ? k : 0];
            end else if (tag && k == int'(count_next)) begin
                ch[k] = ChDot;
            end else if (tag && k == int'(count_next) + 1) begin
                ch[k] = cfg.mode ? cfg.suffix : part_next;
            end else begin
                ch[k] = 8'd0;
            end
        end
        q_data.symbol_head     = {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], ch[6], ch[7]};
        q_data.symbol_tail     = {ch[8], ch[9], ch[10], ch[11], ch[12]};
        q_data.symbol_length   = 4'(n);
        q_data.quote_kind      = kind_next;
        q_data.bid             = bid_next;
        q_data.ask             = ask_next;
        q_data.timestamp_ms    = time_next;
        q_data.sequence_number = seq_next;
        q_data.participant     = part_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            type_reg   <= '{default: 8'd0};
            orig_reg   <= 1'b0;
            seq_reg    <= '0;
            part_reg   <= '0;
            time_reg   <= '0;
            count_reg  <= '0;
            kind_reg   <= '0;
            bid_reg    <= '0;
            ask_reg    <= '0;
            ind_reg    <= '0;
        end else begin
            offset_reg <= offset_next;
            type_reg   <= type_next;
            orig_reg   <= orig_next;
            seq_reg    <= seq_next;
            part_reg   <= part_next;
            time_reg   <= time_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            bid_reg    <= bid_next;
            ask_reg    <= ask_next;
            ind_reg    <= ind_next;
        end
    end

    always_ff @(posedge aclk) begin
        store_reg <= store_next;
    end

endmodule

// ===== src/qfmp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote record queue
// Short queue of finished quote records between parser and result stage.
// ----------------------------------------------------------------------------
module qfmp_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qfmp_pkg::msg_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output qfmp_pkg::msg_t head
);
    import qfmp_pkg::*;

    localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

    msg_t          mem [QueueDepth];
    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == (AW + 1)'(QueueDepth));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == AW'(QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

// ===== src/qfmp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote result stage
// Turns each queued quote record into a bid and an ask result.
// ----------------------------------------------------------------------------
module qfmp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  qfmp_pkg::msg_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output qfmp_pkg::out_t m_data
);
    import qfmp_pkg::*;

    logic  side_reg, side_next;
    logic  valid_reg, valid_next;
    out_t  data_reg, data_next;
    side_t sel;
    logic  load;

    assign load    = head_valid && (!valid_reg || m_ready);
    assign pop     = load && side_reg;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign sel     = side_reg ? head.ask : head.bid;

    always_comb begin
        side_next  = side_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next                = 1'b1;
            side_next                 = !side_reg;
            data_next.side            = side_reg;
            data_next.symbol_head     = head.symbol_head;
            data_next.symbol_tail     = head.symbol_tail;
            data_next.symbol_length   = head.symbol_length;
            data_next.quote_kind      = head.quote_kind;
            data_next.price_digits    = sel.digits;
            data_next.price_power     = sel.power;
            data_next.quantity        = sel.qty;
            data_next.timestamp_ms    = head.timestamp_ms;
            data_next.sequence_number = head.sequence_number;
            data_next.participant     = head.participant;
            data_next.last_of_run     = side_reg;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            side_reg  <= side_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    a_ask_follows_bid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.side) |=> (m_valid && m_data.side))
        else $error("bid transfer not followed by its ask");

    a_last_on_ask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_run == m_data.side))
        else $error("last_of_run does not mark the ask");

    a_pop_after_ask: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (side_reg && head_valid))
        else $error("record released before its ask was loaded");

endmodule

// ===== sim/tb_quote_feed_message_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quote feed message parser testbench
// Feeds directed and random quote messages byte by byte, predicts the bid and
// ask results of each message and checks every result transfer against them.
// ----------------------------------------------------------------------------
module tb_quote_feed_message_parser;
    import qfmp_pkg::*;

    localparam int CycleLimit = 2000000;

    // Scoreboard: a bit-exact copy of the parser state, fed with every accepted
    // byte, and a queue of the bid and ask results that are still owed.
    class quote_scoreboard;
        logic        mode;
        logic [7:0]  suffix;
        logic [7:0]  offs;
        logic [7:0]  typ [3];
        logic        orig;
        logic [29:0] seq;
        logic [7:0]  part;
        logic [26:0] tms;
        logic [7:0]  sym [11];
        logic [3:0]  scount;
        logic [7:0]  qk;
        side_t       bid;
        side_t       ask;
        logic [7:0]  ind [2];
        out_t        owed_q[$];
        int          errors;
        int          results;

        function new();
            mode = 1'b0;
            suffix = 8'd0;
            offs = 8'd0;
            errors = 0;
            results = 0;
            foreach (sym[k]) sym[k] = 8'd0;
            clear();
        endfunction

        function void clear();
            foreach (typ[k]) typ[k] = 8'd0;
            orig = 1'b0;
            seq = '0;
            part = '0;
            tms = '0;
            scount = '0;
            qk = '0;
            bid = '0;
            ask = '0;
            ind[0] = '0;
            ind[1] = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Denominator, price digit or size digit of one side.
        function side_t take(side_t f, int r, int dp, int pp, int pl, int sp, int sl,
                             logic [7:0] b);
            side_t       o;
            logic [7:0]  v;
            logic [39:0] d;
            logic [23:0] q;
            o = f;
            v = b - ChZero;
            if (r == dp) begin
                o.power = (b >= ChLetterA && b <= ChLetterH) ? 4'(b - ChLetterA + 1) : 4'd0;
            end else if (r >= pp && r < pp + pl) begin
                d = (r == pp) ? 40'd0 : f.digits;
                o.digits = d * 40'd10 + 40'(v);
            end else if (r >= sp && r < sp + sl) begin
                q = (r == sp) ? 24'd0 : f.qty;
                o.qty = q * 24'd10 + 24'(v);
            end
            return o;
        endfunction

        function void body(int r, logic [7:0] b, bit lng);
            int symlen;
            int ip;
            int ap;
            int a;
            symlen = lng ? 11 : 3;
            ip = lng ? 76 : 32;
            ap = lng ? 78 : 34;
            if (r < symlen && int'(scount) == r && b != ChSpace && r < 11) begin
                sym[r] = b;
                scount = scount + 1;
            end
            if (r == (lng ? 24 : 3)) qk = b;
            if (lng) begin
                bid = take(bid, r, 27, 28, 12, 40, 7, b);
                ask = take(ask, r, 47, 48, 12, 60, 7, b);
            end else begin
                bid = take(bid, r, 6, 7, 8, 15, 3, b);
                ask = take(ask, r, 19, 20, 8, 28, 3, b);
            end
            if (r == ip) ind[0] = b;
            if (r == ip + 1) ind[1] = b;
            if (r >= ap && mode) begin
                a = r - ap;
                if (ind[0] == ChFour) begin
                    bid = take(bid, a, 3, 16 - 12, 12, 16, 7, b);
                    ask = take(ask, a, 31, 32, 12, 44, 7, b);
                end else if (ind[0] == ChSix) begin
                    bid = take(bid, a, 1, 2, 8, 10, 3, b);
                    ask = take(ask, a, 15, 16, 8, 24, 3, b);
                end
            end
        endfunction

        function bit may_emit(int pos);
            bit lng;
            int need;
            if (!orig || typ[0] != ChLetterE) return 1'b0;
            if (typ[2] != ChLetterE && typ[2] != ChLetterF) return 1'b0;
            if (typ[1] == ChLetterD) lng = 1'b0;
            else if (typ[1] == ChLetterB) lng = 1'b1;
            else return 1'b0;
            need = lng ? 77 : 33;
            if (mode) begin
                if (ind[0] == ChFour) need = (lng ? 78 : 34) + 50;
                else if (ind[0] == ChSix) need = (lng ? 78 : 34) + 26;
                else if (ind[0] != ChOne) return 1'b0;
            end
            return pos >= BodyStart + need;
        endfunction

        function void note_input(in_t x);
            int           pos;
            logic [7:0]   b;
            logic [7:0]   v;
            logic [7:0]   s [13];
            int           n;
            logic [63:0]  head;
            logic [39:0]  tail;
            logic [26:0]  w;
            out_t         e;
            b = x.data_byte;
            v = b - ChZero;
            pos = x.first_byte ? 0 : int'(offs);
            if (pos == 0) begin
                clear();
            end else if (pos <= 3) begin
                typ[pos - 1] = b;
            end else if (pos == 4) begin
                orig = (b == ChLetterO);
            end else if (pos >= 9 && pos <= 17) begin
                seq = ((pos == 9) ? 30'd0 : seq) * 30'd10 + 30'(v);
            end else if (pos == 18) begin
                part = b;
            end else if (pos >= 19 && pos <= 24) begin
                case (pos)
                    19: w = 27'd3600000;
                    20: w = 27'd60000;
                    21: w = 27'd1000;
                    22: w = 27'd100;
                    23: w = 27'd10;
                    default: w = 27'd1;
                endcase
                tms = ((pos == 19) ? 27'd0 : tms) + 27'(v) * w;
            end else if (pos >= BodyStart) begin
                if (typ[1] == ChLetterD) body(pos - BodyStart, b, 1'b0);
                else if (typ[1] == ChLetterB) body(pos - BodyStart, b, 1'b1);
            end
            if (!x.end_of_message) begin
                offs = (pos < 255) ? 8'(pos + 1) : 8'd255;
                return;
            end
            offs = 8'd0;
            if (!may_emit(pos)) return;
            n = 0;
            for (int k = 0; k < int'(scount) && k < 11; k++) begin
                s[n] = sym[k];
                n++;
            end
            if (!mode) begin
                s[n] = ChDot;
                s[n + 1] = part;
                n += 2;
            end else if (suffix != 8'd0) begin
                s[n] = ChDot;
                s[n + 1] = suffix;
                n += 2;
            end
            if (n > 13) n = 13;
            head = '0;
            tail = '0;
            for (int k = 0; k < n; k++) begin
                if (k < 8) head[8*(7-k) +: 8] = s[k];
                else tail[8*(12-k) +: 8] = s[k];
            end
            e.symbol_head = head;
            e.symbol_tail = tail;
            e.symbol_length = 4'(n);
            e.quote_kind = qk;
            e.timestamp_ms = tms;
            e.sequence_number = seq;
            e.participant = part;
            e.side = 1'b0;
            e.last_of_run = 1'b0;
            e.price_digits = bid.digits;
            e.price_power = bid.power;
            e.quantity = bid.qty;
            owed_q = {owed_q, e};
            e.side = 1'b1;
            e.last_of_run = 1'b1;
            e.price_digits = ask.digits;
            e.price_power = ask.power;
            e.quantity = ask.qty;
            owed_q = {owed_q, e};
        endfunction

        function void check(out_t y);
            out_t e;
            results++;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: %h", y);
                return;
            end
            e = owed_q.pop_front();
            if (y.side !== e.side || y.symbol_head !== e.symbol_head ||
                y.symbol_tail !== e.symbol_tail || y.symbol_length !== e.symbol_length ||
                y.quote_kind !== e.quote_kind || y.price_digits !== e.price_digits ||
                y.price_power !== e.price_power || y.quantity !== e.quantity ||
                y.timestamp_ms !== e.timestamp_ms ||
                y.sequence_number !== e.sequence_number ||
                y.participant !== e.participant || y.last_of_run !== e.last_of_run) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch, result %0d", results);
                    $display("  expected %h", e);
                    $display("  actual   %h", y);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    quote_scoreboard sb;
    logic [7:0]      msg_q[$];
    int              bytes_sent;
    int              msgs_sent;
    int              cycles;
    int              hold_cycles;
    int              hold_requests;
    int              hold_served;
    bit              no_idle;

    quote_feed_message_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // The run is cut off if it ever hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_quote_feed_message_parser NOT OK");
            $finish;
        end
    end

    // Result side: every accepted transfer is checked, then ready is chosen for
    // the next cycle. A long hold-off requested by the sender is counted here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check(m_data);
            if (hold_requests != hold_served) begin
                hold_served <= hold_requests;
                hold_cycles <= 400;
                m_ready <= 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                hold_cycles <= $urandom_range(10, 40);
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    // Most gaps are short; now and then a long one.
    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one byte and waits for its transfer; called at a rising edge.
    task automatic send_byte(in_t x);
        int g;
        g = idle_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(x);
        bytes_sent++;
    endtask

    // Sends the built message; the first byte carries first_byte if asked.
    task automatic send_msg(bit mark_first);
        in_t x;
        for (int i = 0; i < msg_q.size(); i++) begin
            x.data_byte = msg_q[i];
            x.first_byte = (i == 0) && mark_first;
            x.end_of_message = (i == msg_q.size() - 1);
            send_byte(x);
        end
        msgs_sent++;
    endtask

    // Lets the block run dry: every owed result in, then a margin for the
    // output register and the queue.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == {RegNbboMode, 2'b00}) sb.mode = value[0];
        else sb.suffix = value[7:0];
    endtask

    task automatic set_config(logic m, logic [7:0] s);
        write_reg({RegNbboMode, 2'b00}, {31'd0, m});
        @(posedge aclk);
        write_reg({RegNbboSuffix, 2'b00}, {24'd0, s});
    endtask

    function automatic logic [7:0] digit_char(bit junk);
        if (junk || $urandom_range(0, 99) < 3) return 8'($urandom);
        return ChZero + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] denom_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return ChLetterA + 8'($urandom_range(0, 7));
        if (r < 80) return ChLetterH + 8'd1;
        if (r < 88) return ChLetterA - 8'd1;
        return 8'($urandom);
    endfunction

    // Builds a quote message into msg_q. Variants: 0 well formed, 1 retransmitted,
    // 2 not a quote type, 3 cut short, 4 all digits junk, 5 over-long.
    task automatic build_quote(bit lng, logic [7:0] indc, int variant);
        int last;
        int bs;
        int ap;
        int k;
        int symlen;
        bit junk;
        junk = (variant == 4);
        symlen = lng ? 11 : 3;
        ap = lng ? 78 : 34;
        if (indc == ChFour) last = BodyStart + ap + 50;
        else if (indc == ChSix) last = BodyStart + ap + 26;
        else last = BodyStart + (lng ? 77 : 33);
        last += $urandom_range(0, 3);
        if (variant == 3) last = $urandom_range(1, last - 1);
        if (variant == 5) last = $urandom_range(256, 300);
        msg_q.delete();
        msg_q = {msg_q, (($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01)};
        msg_q = {msg_q, ChLetterE};
        msg_q = {msg_q, (lng ? ChLetterB : ChLetterD)};
        msg_q = {msg_q, ($urandom_range(0, 1) ? ChLetterE : ChLetterF)};
        msg_q = {msg_q, ((variant == 1) ? (8'($urandom_range(0, 254)) | 8'h01 ^ 8'h00)
                                        : ChLetterO)};
        if (variant == 1 && msg_q[4] == ChLetterO) msg_q[4] = ChLetterO + 8'd1;
        if (variant == 2) begin
            k = $urandom_range(1, 3);
            msg_q[k] = msg_q[k] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 5; i <= 8; i++) msg_q = {msg_q, 8'($urandom)};
        for (int i = 9; i <= 17; i++) msg_q = {msg_q, digit_char(junk)};
        msg_q = {msg_q, 8'($urandom)};
        for (int i = 19; i <= 24; i++) msg_q = {msg_q, digit_char(junk)};
        // Filled past every fixed field position; trimmed to length below.
        for (int i = BodyStart; i <= last || i < 160; i++) msg_q = {msg_q, digit_char(junk)};
        // Symbol characters, cut at a random space.
        k = $urandom_range(0, symlen);
        for (int r = 0; r < symlen; r++) begin
            if (r < k) msg_q[BodyStart + r] = ChLetterA + 8'($urandom_range(0, 25));
            else if (r == k) msg_q[BodyStart + r] = ChSpace;
            else msg_q[BodyStart + r] = $urandom_range(0, 1) ? ChSpace : 8'($urandom);
        end
        bs = BodyStart + (lng ? 24 : 3);
        msg_q[bs] = 8'($urandom);
        msg_q[BodyStart + (lng ? 27 : 6)] = denom_char();
        msg_q[BodyStart + (lng ? 47 : 19)] = denom_char();
        msg_q[BodyStart + (lng ? 76 : 32)] = indc;
        msg_q[BodyStart + (lng ? 77 : 33)] = 8'($urandom);
        if (indc == ChFour) begin
            msg_q[BodyStart + ap + 3] = denom_char();
            msg_q[BodyStart + ap + 31] = denom_char();
        end else if (indc == ChSix) begin
            msg_q[BodyStart + ap + 1] = denom_char();
            msg_q[BodyStart + ap + 15] = denom_char();
        end
        while (msg_q.size() > last + 1) void'(msg_q.pop_back());
    endtask

    function automatic logic [7:0] rand_indicator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return ChOne;
        if (r < 60) return ChFour;
        if (r < 88) return ChSix;
        return 8'($urandom);
    endfunction

    // A few bytes of noise with random flags, closed by an end of message.
    task automatic send_noise();
        in_t x;
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            x = in_t'(10'($urandom));
            if (i == n - 1) x.end_of_message = 1'b1;
            send_byte(x);
        end
    endtask

    task automatic random_message();
        int r;
        int variant;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            send_noise();
            return;
        end
        if (r < 72) variant = 0;
        else if (r < 78) variant = 1;
        else if (r < 84) variant = 2;
        else if (r < 93) variant = 3;
        else if (r < 98) variant = 4;
        else variant = 5;
        build_quote($urandom_range(0, 99) < 30, rand_indicator(), variant);
        send_msg($urandom_range(0, 99) < 85);
    endtask

    initial begin
        logic        modes [6];
        logic [7:0]  suffixes [6];
        int          start_bytes;
        int          phase_msgs;
        sb = new();
        aresetn = 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        bytes_sent = 0;
        msgs_sent = 0;
        cycles = 0;
        hold_requests = 0;
        no_idle = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, participant tagging first.
        set_config(1'b0, 8'd0);
        build_quote(1'b1, ChOne, 0);
        send_msg(1'b1);
        build_quote(1'b0, ChOne, 0);
        send_msg(1'b0);
        build_quote(1'b0, ChFour, 1);
        send_msg(1'b1);
        build_quote(1'b1, ChSix, 2);
        send_msg(1'b1);
        build_quote(1'b0, ChOne, 3);
        send_msg(1'b1);
        build_quote(1'b0, ChOne, 4);
        send_msg(1'b1);
        build_quote(1'b1, ChFour, 5);
        send_msg(1'b1);
        // A message broken off by first_byte on a fresh message.
        build_quote(1'b1, ChOne, 0);
        msg_q = msg_q[0:39];
        for (int i = 0; i < 40; i++) send_byte(in_t'({msg_q[i], i == 0, 1'b0}));
        build_quote(1'b0, ChSix, 0);
        send_msg(1'b1);
        drain();
        set_config(1'b1, 8'h5A);
        build_quote(1'b1, ChFour, 0);
        send_msg(1'b1);
        build_quote(1'b0, ChSix, 0);
        send_msg(1'b1);
        build_quote(1'b0, ChOne, 0);
        send_msg(1'b1);
        build_quote(1'b1, 8'h32, 0);
        send_msg(1'b1);
        drain();

        // Random part over several settings, the extremes among them.
        modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        suffixes = '{8'd0, 8'd0, 8'hFF, 8'hFF, 8'h41, 8'h01};
        for (int p = 0; p < 6; p++) begin
            if (p == 5) set_config(1'($urandom), 8'($urandom));
            else set_config(modes[p], suffixes[p]);
            no_idle = (p == 4);
            start_bytes = bytes_sent;
            phase_msgs = 0;
            while (bytes_sent - start_bytes < 60 && phase_msgs < 400) begin
                if (p == 2 && phase_msgs == 0) begin
                    // Stall the result side and keep bytes coming at full rate.
                    hold_requests++;
                    no_idle = 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        build_quote(1'b0, ChOne, 0);
                        send_msg(1'b1);
                    end
                    no_idle = 1'b0;
                end
                if (p == 3 && phase_msgs == 1) begin
                    drain();
                end
                random_message();
                phase_msgs++;
            end
            drain();
        end

        $display("%0d bytes in %0d messages, %0d results checked, %0d errors",
                 bytes_sent, msgs_sent, sb.results, sb.errors);
        $display("covered short and long quotes in both tag modes, NBBO appendices, stalls");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_quote_feed_message_parser OK");
        end else begin
            $display("tb_quote_feed_message_parser NOT OK");
        end
        $finish;
    end

endmodule
